@@ rtl/core/sdps_pkg.sv @@
// shared constants, types and round functions for the differential pair screener
`default_nettype none
package sdps_pkg;

   localparam int ScreenRounds = 57;
   localparam int TrialRounds = 4;

   localparam logic [31:0] KernelReset = 32'h4000_0000;
   localparam logic [31:0] FillReset = 32'hffff_ffff;
   localparam logic [15:0] TrialReset = 16'd1000;
   localparam logic [31:0] SeedReset = 32'h0000_0001;

   localparam logic [1:0] CsrKernel = 2'd0;
   localparam logic [1:0] CsrFill = 2'd1;
   localparam logic [1:0] CsrTrials = 2'd2;
   localparam logic [1:0] CsrSeed = 2'd3;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] vars_type;

   localparam vars_type InitHash = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[idx];
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type small0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic vars_type one_round(input vars_type v, input word_type k,
                                          input word_type w);
      word_type t1;
      word_type t2;
      vars_type r;
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      r[7] = v[6];
      r[6] = v[5];
      r[5] = v[4];
      r[4] = v[3] + t1;
      r[3] = v[2];
      r[2] = v[1];
      r[1] = v[0];
      r[0] = t1 + t2;
      return r;
   endfunction

   function automatic logic [5:0] pop32(input word_type x);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         n = n + 6'(x[i]);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha256_differential_pair_screener_top.sv @@
// top level of the sha-256 differential pair screener
`default_nettype none
// Takes one candidate word and runs two messages through SCREEN_ROUNDS sha-256
// rounds, one round of both messages per cycle in a shared round unit. When the
// a words match, each trial reloads the saved state, runs TRIAL_ROUNDS rounds
// (one generator word per cycle) and then adds its distance, and the floor mean
// is a bit-serial divide (the mean is zero when the trial count is zero); the
// result then waits on rsp until it is taken.
// req_tready is low while a word is in work or a result waits on rsp.
module sha256_differential_pair_screener_top #(
   parameter int SCREEN_ROUNDS = sdps_pkg::ScreenRounds,
   parameter int TRIAL_ROUNDS = sdps_pkg::TrialRounds
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // candidate_word
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // hit_word, state_distance, best, average
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);
   import sdps_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SCRN  = 8'b0000_0010,
      S_CHECK = 8'b0000_0100,
      S_TLOAD = 8'b0000_1000,
      S_TRND  = 8'b0001_0000,
      S_TDIST = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   word_type   kern_ff, fill_ff, prng_ff, prng_in;
   logic [15:0] trials_ff;
   word_type   win1_ff [16];
   word_type   win2_ff [16];
   vars_type   v1_ff, v2_ff, s1_ff, s2_ff, r1, r2;
   word_type   cand_ff, w1_hold_ff;
   logic [5:0] t_ff;
   logic [15:0] n_ff;
   logic [8:0] dist_ff, best_ff, trial_d;
   logic [24:0] sum_ff;
   logic [24:0] rem_ff;
   logic [24:0] quo_ff;
   logic [4:0] bit_ff;
   logic       half_ff;
   word_type   w1, w2, wn1, wn2, xs;
   logic [3:0] ti;
   logic [5:0] kidx;
   logic [25:0] rem_sh;

   assign csr_ready = state_ff == S_IDLE;
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_OUT;
   assign rsp_tdata = {5'd0, quo_ff[8:0], best_ff, dist_ff, cand_ff};

   assign ti = t_ff[3:0];
   assign wn1 = small1(win1_ff[ti - 4'd2]) + win1_ff[ti - 4'd7]
              + small0(win1_ff[ti - 4'd15]) + win1_ff[ti];
   assign wn2 = small1(win2_ff[ti - 4'd2]) + win2_ff[ti - 4'd7]
              + small0(win2_ff[ti - 4'd15]) + win2_ff[ti];

   always_comb begin
      xs = prng_ff ^ (prng_ff << 13);
      xs = xs ^ (xs >> 17);
      xs = xs ^ (xs << 5);
   end

   always_comb begin
      trial_d = '0;
      for (int i = 0; i < 8; i++) begin
         trial_d = trial_d + 9'(pop32(v1_ff[i] ^ v2_ff[i]));
      end
   end

   always_comb begin
      if (state_ff == S_SCRN) begin
         w1 = (t_ff < 6'd16) ? win1_ff[ti] : wn1;
         w2 = (t_ff < 6'd16) ? win2_ff[ti] : wn2;
         kidx = t_ff;
      end else begin
         w1 = w1_hold_ff;
         w2 = xs;
         kidx = 6'(SCREEN_ROUNDS) + t_ff;
      end
   end

   sdps_round_unit u_round (
      .v1(v1_ff), .v2(v2_ff), .k(round_k(kidx)), .w1(w1), .w2(w2), .r1(r1), .r2(r2)
   );

   assign rem_sh = {rem_ff, sum_ff[5'd24 - bit_ff]};

   always_comb begin
      state_in = state_ff;
      prng_in = prng_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_SCRN;
         S_SCRN: if (t_ff == 6'(SCREEN_ROUNDS - 1)) state_in = S_CHECK;
         S_CHECK: begin
            if (v1_ff[0] != v2_ff[0]) state_in = S_IDLE;
            else if (trials_ff == 16'd0) state_in = S_DIV;
            else state_in = S_TLOAD;
         end
         S_TLOAD: state_in = S_TRND;
         S_TRND: begin
            prng_in = xs;
            if (half_ff && t_ff == 6'(TRIAL_ROUNDS - 1)) state_in = S_TDIST;
         end
         S_TDIST: state_in = (n_ff == trials_ff - 16'd1) ? S_DIV : S_TLOAD;
         S_DIV: if (bit_ff == 5'd24 || trials_ff == 16'd0) state_in = S_OUT;
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE && csr_valid && csr_index == CsrSeed) prng_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kern_ff <= KernelReset;
         fill_ff <= FillReset;
         trials_ff <= TrialReset;
         prng_ff <= SeedReset;
      end else begin
         state_ff <= state_in;
         prng_ff <= prng_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CsrKernel: kern_ff <= csr_data;
               CsrFill: fill_ff <= csr_data;
               CsrTrials: trials_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            cand_ff <= req_tdata;
            for (int i = 0; i < 16; i++) begin
               if (i == 0) begin
                  win1_ff[4'(i)] <= req_tdata;
                  win2_ff[4'(i)] <= req_tdata ^ kern_ff;
               end else if (i == 9) begin
                  win1_ff[4'(i)] <= fill_ff;
                  win2_ff[4'(i)] <= fill_ff ^ kern_ff;
               end else begin
                  win1_ff[4'(i)] <= fill_ff;
                  win2_ff[4'(i)] <= fill_ff;
               end
            end
            v1_ff <= InitHash;
            v2_ff <= InitHash;
            t_ff <= '0;
         end
         S_SCRN: begin
            win1_ff[ti] <= w1;
            win2_ff[ti] <= w2;
            v1_ff <= r1;
            v2_ff <= r2;
            t_ff <= t_ff + 6'd1;
         end
         S_CHECK: begin
            s1_ff <= v1_ff;
            s2_ff <= v2_ff;
            dist_ff <= trial_d;
            best_ff <= 9'd256;
            sum_ff <= '0;
            n_ff <= '0;
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= '0;
         end
         S_TLOAD: begin
            v1_ff <= s1_ff;
            v2_ff <= s2_ff;
            t_ff <= '0;
            half_ff <= 1'b0;
         end
         S_TRND: begin
            half_ff <= ~half_ff;
            if (!half_ff) begin
               w1_hold_ff <= xs;
            end else begin
               v1_ff <= r1;
               v2_ff <= r2;
               t_ff <= t_ff + 6'd1;
            end
         end
         S_TDIST: begin
            if (trial_d < best_ff) best_ff <= trial_d;
            sum_ff <= sum_ff + 25'(trial_d);
            n_ff <= n_ff + 16'd1;
         end
         S_DIV: begin
            if (trials_ff == 16'd0) begin
               quo_ff <= '0;
            end else if (rem_sh >= 26'(trials_ff)) begin
               rem_ff <= 25'(rem_sh - 26'(trials_ff));
               quo_ff <= {quo_ff[23:0], 1'b1};
            end else begin
               rem_ff <= 25'(rem_sh);
               quo_ff <= {quo_ff[23:0], 1'b0};
            end
            bit_ff <= bit_ff + 5'd1;
         end
         S_OUT: ;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/sdps_round_unit.sv @@
// shared combinational sha-256 round unit that advances both messages by one round
`default_nettype none
module sdps_round_unit (
   input  wire sdps_pkg::vars_type v1,
   input  wire sdps_pkg::vars_type v2,
   input  wire sdps_pkg::word_type k,
   input  wire sdps_pkg::word_type w1,
   input  wire sdps_pkg::word_type w2,
   output sdps_pkg::vars_type      r1,
   output sdps_pkg::vars_type      r2
);
   import sdps_pkg::*;

   assign r1 = one_round(v1, k, w1);
   assign r2 = one_round(v2, k, w2);

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// testbench for the sha-256 differential pair screener: directed rows and random words
`timescale 1ns / 1ps
module tb_top;
   import sdps_pkg::*;

   localparam int CycleLimit = 4_000_000;
   localparam int HoldCycles = 3000;
   localparam int SettleCycles = 100;

   localparam word_type RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   typedef struct packed {
      logic [31:0] hit_word;
      logic [8:0]  state_dist;
      logic [8:0]  best_dist;
      logic [8:0]  mean_dist;
   } hit_rec_type;

   typedef struct {
      word_type    kernel;
      word_type    fill;
      logic [15:0] trials;
      word_type    seed;
   } screen_cfg_type;

   typedef struct {
      int          phase;
      word_type    cand;
      bit          typed;
      hit_rec_type hit;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   word_type    kernel_reg;
   word_type    fill_reg;
   logic [15:0] trials_reg;
   word_type    gen_state;
   hit_rec_type hit_queue [$];
   int          mismatches;
   int          hits_seen;
   int          cycles;
   bit          hold_done;

   sha256_differential_pair_screener_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data));

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic word_type ror32(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic vars_type sha_round(input vars_type v, input word_type k,
                                          input word_type w);
      word_type t1;
      word_type t2;
      vars_type r;
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      r = {v[6:4], v[3] + t1, v[2:0], t1 + t2};
      return r;
   endfunction

   // all words equal fill except words 0 and 9
   function automatic vars_type screen_msg(input word_type w0, input word_type w9);
      word_type win [16];
      word_type w;
      vars_type v;
      for (int i = 0; i < 16; i++) win[i] = fill_reg;
      win[0] = w0;
      win[9] = w9;
      v = InitHash;
      for (int t = 0; t < ScreenRounds; t++) begin
         if (t < 16) begin
            w = win[t];
         end else begin
            w = (ror32(win[(t - 2) % 16], 17) ^ ror32(win[(t - 2) % 16], 19)
                 ^ (win[(t - 2) % 16] >> 10))
              + win[(t - 7) % 16]
              + (ror32(win[(t - 15) % 16], 7) ^ ror32(win[(t - 15) % 16], 18)
                 ^ (win[(t - 15) % 16] >> 3))
              + win[t % 16];
            win[t % 16] = w;
         end
         v = sha_round(v, RoundK[t % 64], w);
      end
      return v;
   endfunction

   function automatic word_type xorshift_next();
      word_type x;
      x = gen_state;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      gen_state = x;
      return x;
   endfunction

   // returns 1 when the a words match
   function automatic bit screen_word(input word_type cand, output hit_rec_type rec);
      vars_type sa;
      vars_type sb;
      vars_type ta;
      vars_type tb;
      word_type r1;
      word_type r2;
      word_type sum;
      logic [8:0] d;
      logic [8:0] best;
      sa = screen_msg(cand, fill_reg);
      sb = screen_msg(cand ^ kernel_reg, fill_reg ^ kernel_reg);
      rec = '0;
      if (sa[0] != sb[0]) return 0;
      best = 9'd256;
      sum = '0;
      for (int n = 0; n < trials_reg; n++) begin
         ta = sa;
         tb = sb;
         for (int r = 0; r < TrialRounds; r++) begin
            r1 = xorshift_next();
            r2 = xorshift_next();
            ta = sha_round(ta, RoundK[(ScreenRounds + r) % 64], r1);
            tb = sha_round(tb, RoundK[(ScreenRounds + r) % 64], r2);
         end
         d = 9'($countones(ta ^ tb));
         if (d < best) best = d;
         sum += 32'(d);
      end
      rec.hit_word = cand;
      rec.state_dist = 9'($countones(sa ^ sb));
      rec.best_dist = best;
      rec.mean_dist = (trials_reg != 0) ? 9'(sum / trials_reg) : 9'd0;
      return 1;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input word_type value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CsrKernel: kernel_reg = value;
         CsrFill: fill_reg = value;
         CsrTrials: trials_reg = value[15:0];
         CsrSeed: begin
            gen_state = value;
         end
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain_and_settle();
      req_tvalid = 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_cfg(input screen_cfg_type c);
      drain_and_settle();
      csr_write(CsrKernel, c.kernel);
      csr_write(CsrFill, c.fill);
      csr_write(CsrTrials, {16'd0, c.trials});
      csr_write(CsrSeed, c.seed);
   endtask

   // called at a falling edge, returns at the falling edge after the word is taken, with valid still high
   task automatic send_word(input word_type cand, input bit typed,
                            input hit_rec_type fixed);
      hit_rec_type rec;
      bit hit;
      req_tvalid = 1'b1;
      req_tdata = cand;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit = screen_word(cand, rec);
      if (typed) hit_queue.push_back(fixed);
      else if (hit) hit_queue.push_back(rec);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   screen_cfg_type dir_cfg [6];
   stim_row_type rows [$];

   initial begin
      screen_cfg_type rc;
      int burst;
      int sent;
      stim_row_type row;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CsrKernel;
      csr_data = '0;
      kernel_reg = KernelReset;
      fill_reg = FillReset;
      trials_reg = TrialReset;
      gen_state = SeedReset;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero trial count, equal messages
      dir_cfg[0] = '{32'h0, 32'h0, 16'd0, 32'h1};
      dir_cfg[1] = '{KernelReset, FillReset, TrialReset, SeedReset};
      dir_cfg[2] = '{32'hffff_ffff, 32'h0, 16'd5, 32'h1234_5678};
      // zero seed gives zero random words
      dir_cfg[3] = '{32'h0, 32'hffff_ffff, 16'd3, 32'h0};
      dir_cfg[4] = '{32'h0, 32'h5555_aaaa, 16'd1, 32'hffff_ffff};
      dir_cfg[5] = '{32'h0, 32'h0, 16'hffff, 32'h8000_0001};
      rows = '{
         '{0, 32'h0000_0000, 1, '{32'h0000_0000, 9'd0, 9'd256, 9'd0}},
         '{0, 32'hffff_ffff, 1, '{32'hffff_ffff, 9'd0, 9'd256, 9'd0}},
         '{0, 32'h8000_0000, 1, '{32'h8000_0000, 9'd0, 9'd256, 9'd0}},
         '{0, 32'h0000_0001, 1, '{32'h0000_0001, 9'd0, 9'd256, 9'd0}},
         '{1, 32'h0000_0000, 0, '0},
         '{1, 32'hffff_ffff, 0, '0},
         '{1, 32'h4000_0000, 0, '0},
         '{1, 32'h1234_5678, 0, '0},
         '{2, 32'h0000_0000, 0, '0},
         '{2, 32'hffff_ffff, 0, '0},
         '{2, 32'hdead_beef, 0, '0},
         '{3, 32'h0000_0000, 1, '{32'h0000_0000, 9'd0, 9'd0, 9'd0}},
         '{3, 32'hffff_ffff, 1, '{32'hffff_ffff, 9'd0, 9'd0, 9'd0}},
         '{3, 32'ha5a5_a5a5, 1, '{32'ha5a5_a5a5, 9'd0, 9'd0, 9'd0}},
         '{4, 32'h0000_0000, 0, '0},
         '{4, 32'hffff_ffff, 0, '0},
         '{4, 32'h7fff_ffff, 0, '0},
         '{4, 32'h0f0f_0f0f, 0, '0},
         '{5, 32'h3c3c_c3c3, 0, '0}};

      for (int i = 0; i < rows.size(); i++) begin
         row = rows[i];
         if (i == 0 || rows[i - 1].phase != row.phase) load_cfg(dir_cfg[row.phase]);
         send_word(row.cand, row.typed, row.hit);
         idle_gap();
      end

      for (int p = 0; p < 10; p++) begin
         rc.kernel = ($urandom_range(0, 1) == 0 || p == 1) ? 32'h0 : $urandom;
         case ($urandom_range(0, 3))
            0: rc.fill = 32'h0;
            1: rc.fill = 32'hffff_ffff;
            default: rc.fill = $urandom;
         endcase
         rc.trials = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
         rc.seed = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
         load_cfg(rc);
         sent = 0;
         while (sent < 153) begin
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst && sent < 153; b++) begin
               send_word($urandom, 0, '0);
               sent++;
            end
            if (p % 3 != 2) idle_gap();
         end
      end

      drain_and_settle();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver: alternating open and stalling stretches plus one long hold-off
   initial begin
      int hold;
      int stretch;
      bit stalling;
      rsp_tready = 1'b0;
      hold = 0;
      stretch = 0;
      stalling = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_tvalid && hits_seen >= 40) begin
            hold_done = 1'b1;
            hold = HoldCycles;
         end
         if (stretch == 0) begin
            stretch = $urandom_range(50, 300);
            stalling = ~stalling;
         end
         stretch--;
         if (hold != 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else if (stalling) begin
            rsp_tready = ($urandom_range(0, 3) != 0);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      mismatches = 0;
      hits_seen = 0;
      cycles = 0;
   end

   always @(posedge clock) begin
      hit_rec_type want;
      hit_rec_type got;
      int errs;
      errs = 0;
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit_word = rsp_tdata[31:0];
         got.state_dist = rsp_tdata[40:32];
         got.best_dist = rsp_tdata[49:41];
         got.mean_dist = rsp_tdata[58:50];
         hits_seen <= hits_seen + 1;
         if (hit_queue.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            errs++;
         end else begin
            want = hit_queue.pop_front();
            if (got.hit_word !== want.hit_word) begin
               $error("hit_word expected %h got %h", want.hit_word, got.hit_word);
               errs++;
            end
            if (got.state_dist !== want.state_dist) begin
               $error("state_distance expected %0d got %0d", want.state_dist,
                      got.state_dist);
               errs++;
            end
            if (got.best_dist !== want.best_dist) begin
               $error("best_trial_distance expected %0d got %0d", want.best_dist,
                      got.best_dist);
               errs++;
            end
            if (got.mean_dist !== want.mean_dist) begin
               $error("average_trial_distance expected %0d got %0d", want.mean_dist,
                      got.mean_dist);
               errs++;
            end
         end
      end
      if (errs != 0) mismatches <= mismatches + errs;
   end

endmodule

@@ sha256_differential_pair_screener_top.f @@
rtl/core/sdps_pkg.sv
rtl/core/sdps_round_unit.sv
rtl/core/sha256_differential_pair_screener_top.sv
bench/tb_top.sv
